// ===== hdl/mpct_pkg.sv =====
// Shared types and constants for the MIDI pedal controller tracker.
// No dependencies; every module of the block imports this package.
package mpct_pkg;

    localparam int unsigned BYTE_W = 8;

    localparam logic [BYTE_W-1:0] TAG_OVERFLOW    = 8'hF8;
    localparam logic [BYTE_W-1:0] ONE_DATA_LOW    = 8'hC0;
    localparam logic [BYTE_W-1:0] ONE_DATA_HIGH   = 8'hDF;
    localparam logic [BYTE_W-1:0] MARK_LOW        = 8'hF0;
    localparam logic [3:0]        CONTROL_KIND    = 4'hB;
    localparam logic [BYTE_W-1:0] CTRL_SUSTAIN    = 8'h40;
    localparam logic [BYTE_W-1:0] CTRL_PORTAMENTO = 8'h41;
    localparam logic [BYTE_W-1:0] PEDAL_REST_RESET = 8'h00;

    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_STATUS = 2'd1,
        PH_FIRST  = 2'd2,
        PH_SECOND = 2'd3
    } parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] stream_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] pedal_rest_value;
    } cfg_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sustain_value;
        logic [BYTE_W-1:0] portamento_value;
        logic              sustain_changed;
        logic              portamento_changed;
        logic              frame_done;
    } result_beat_t;

    function automatic logic has_one_data(input logic [BYTE_W-1:0] status);
        return (status >= ONE_DATA_LOW) && (status <= ONE_DATA_HIGH);
    endfunction

endpackage

// ===== hdl/mpct_chan_if.sv =====
// Valid/ready channel carrying one beat of a given payload type.
// Payload types come from mpct_pkg.
interface mpct_chan_if #(
    parameter type payload_t = logic [7:0]
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/mpct_input_stage.sv =====
// Input register of the tracker: holds one accepted byte beat.
// Depends on mpct_pkg.
module mpct_input_stage (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      beat_valid,
    output logic                      beat_ready,
    input  logic [mpct_pkg::BYTE_W-1:0] beat_byte,
    input  logic                      advance,
    output logic                      held_valid,
    output logic [mpct_pkg::BYTE_W-1:0] held_byte
);
    import mpct_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;

    assign beat_ready = !valid_reg || advance;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (beat_ready)
        begin
            valid_next = beat_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_valid && beat_ready)
        begin
            byte_reg <= beat_byte;
        end
    end
endmodule

// ===== hdl/mpct_parser.sv =====
// Running-status parser: frame phase, running status, controller number
// and both pedal levels. Depends on mpct_pkg.
module mpct_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic [mpct_pkg::BYTE_W-1:0] cur_byte,
    input  logic                        cfg_write,
    input  logic [mpct_pkg::BYTE_W-1:0] cfg_value,
    output mpct_pkg::result_beat_t      result
);
    import mpct_pkg::*;

    parse_phase_t      phase_reg;
    parse_phase_t      phase_next;
    logic [BYTE_W-1:0] status_reg;
    logic [BYTE_W-1:0] status_next;
    logic [BYTE_W-1:0] ctrl_reg;
    logic [BYTE_W-1:0] ctrl_next;
    logic [BYTE_W-1:0] sustain_reg;
    logic [BYTE_W-1:0] sustain_next;
    logic [BYTE_W-1:0] porta_reg;
    logic [BYTE_W-1:0] porta_next;
    logic              is_status;
    logic              short_msg;
    logic              is_control;

    assign is_status  = cur_byte[BYTE_W-1];
    assign short_msg  = has_one_data(status_reg);
    assign is_control = (status_reg[BYTE_W-1 -: 4] == CONTROL_KIND);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_TAG:
            begin
                if (cur_byte != TAG_OVERFLOW)
                begin
                    phase_next = PH_STATUS;
                end
            end
            PH_STATUS:
            begin
                if (is_status)
                begin
                    phase_next = (cur_byte >= MARK_LOW) ? PH_TAG : PH_FIRST;
                end
                else
                begin
                    phase_next = short_msg ? PH_TAG : PH_SECOND;
                end
            end
            PH_FIRST:
            begin
                phase_next = short_msg ? PH_TAG : PH_SECOND;
            end
            PH_SECOND:
            begin
                phase_next = PH_TAG;
            end
            default:
            begin
                phase_next = PH_TAG;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        status_next  = status_reg;
        ctrl_next    = ctrl_reg;
        sustain_next = sustain_reg;
        porta_next   = porta_reg;
        result       = '0;
        unique case (phase_reg)
            PH_TAG:
            begin
                result.frame_done = (cur_byte == TAG_OVERFLOW);
            end
            PH_STATUS:
            begin
                if (is_status)
                begin
                    status_next       = cur_byte;
                    result.frame_done = (cur_byte >= MARK_LOW);
                end
                else if (short_msg)
                begin
                    result.frame_done = 1'b1;
                end
                else
                begin
                    ctrl_next = cur_byte;
                end
            end
            PH_FIRST:
            begin
                if (short_msg)
                begin
                    result.frame_done = 1'b1;
                end
                else
                begin
                    ctrl_next = cur_byte;
                end
            end
            PH_SECOND:
            begin
                result.frame_done = 1'b1;
                if (is_control && (ctrl_reg == CTRL_SUSTAIN))
                begin
                    sustain_next           = cur_byte;
                    result.sustain_changed = 1'b1;
                end
                else if (is_control && (ctrl_reg == CTRL_PORTAMENTO))
                begin
                    porta_next                = cur_byte;
                    result.portamento_changed = 1'b1;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
        result.sustain_value    = sustain_next;
        result.portamento_value = porta_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TAG;
            status_reg  <= '0;
            ctrl_reg    <= '0;
            sustain_reg <= PEDAL_REST_RESET;
            porta_reg   <= PEDAL_REST_RESET;
        end
        else if (cfg_write)
        begin
            sustain_reg <= cfg_value;
            porta_reg   <= cfg_value;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            status_reg  <= status_next;
            ctrl_reg    <= ctrl_next;
            sustain_reg <= sustain_next;
            porta_reg   <= porta_next;
        end
    end
endmodule

// ===== hdl/mpct_result_stage.sv =====
// Result register of the tracker: holds one result beat until taken.
// Depends on mpct_pkg.
module mpct_result_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load_valid,
    output logic                   load_ready,
    input  mpct_pkg::result_beat_t load_beat,
    output logic                   beat_valid,
    input  logic                   beat_ready,
    output mpct_pkg::result_beat_t beat
);
    import mpct_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_beat_t beat_reg;

    assign load_ready = !valid_reg || beat_ready;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ready)
        begin
            valid_next = load_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            beat_reg <= load_beat;
        end
    end
endmodule

// ===== hdl/midi_pedal_controller_tracker.sv =====
// Pedal controller tracker: top level joining input register, parser and
// result register. Depends on mpct_pkg, mpct_chan_if and the mpct stages.
//
// Takes one byte of a timed MIDI stream per beat on byte_ch and returns one
// result beat per byte on result_ch: both pedal levels after the byte, a
// changed flag for each, and a frame-done flag. A new byte is accepted every
// cycle unless backpressure holds it; each result passes through the input
// register and then the result register, and the whole parse of a byte sits
// in the single combinational step between those registers.
// Backpressure on result_ch stalls byte_ch only when both registers are full.
// A beat on cfg_ch loads both pedal levels with the written rest value; it is
// always ready and is meant for use while the stream is idle.
module midi_pedal_controller_tracker (
    input  logic        clk,
    input  logic        rst_n,
    mpct_chan_if.sink   byte_ch,
    mpct_chan_if.source result_ch,
    mpct_chan_if.sink   cfg_ch
);
    import mpct_pkg::*;

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              load_ready;
    logic              advance;
    result_beat_t      parsed;
    result_beat_t      out_beat;
    logic              cfg_write;

    assign advance   = held_valid && load_ready;
    assign cfg_write = cfg_ch.valid && cfg_ch.ready;
    assign cfg_ch.ready = 1'b1;

    mpct_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (byte_ch.valid),
        .beat_ready (byte_ch.ready),
        .beat_byte  (byte_ch.payload.stream_byte),
        .advance    (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    mpct_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cur_byte  (held_byte),
        .cfg_write (cfg_write),
        .cfg_value (cfg_ch.payload.pedal_rest_value),
        .result    (parsed)
    );

    mpct_result_stage u_result (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_ready (load_ready),
        .load_beat  (parsed),
        .beat_valid (result_ch.valid),
        .beat_ready (result_ch.ready),
        .beat       (out_beat)
    );

    assign result_ch.payload = out_beat;
endmodule

// ===== dv/tb_midi_pedal_controller_tracker.sv =====
`timescale 1ns / 100ps
// Testbench for midi_pedal_controller_tracker: random timed MIDI frames checked
// beat by beat against an in-bench parser model. Depends on mpct_pkg and mpct_chan_if.
module tb_midi_pedal_controller_tracker;
    import mpct_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              byte_valid_d = 1'b0;
    logic [BYTE_W-1:0] byte_data_d  = '0;
    logic              res_ready_d  = 1'b0;
    logic              cfg_valid_d  = 1'b0;
    logic [BYTE_W-1:0] cfg_data_d   = '0;

    mpct_chan_if #(.payload_t(byte_beat_t))   byte_ch ();
    mpct_chan_if #(.payload_t(result_beat_t)) result_ch ();
    mpct_chan_if #(.payload_t(cfg_beat_t))    cfg_ch ();

    assign byte_ch.valid   = byte_valid_d;
    assign byte_ch.payload = byte_data_d;
    assign result_ch.ready = res_ready_d;
    assign cfg_ch.valid    = cfg_valid_d;
    assign cfg_ch.payload  = cfg_data_d;

    midi_pedal_controller_tracker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    always #5 clk = ~clk;

    logic [BYTE_W-1:0] pending_bytes[$];
    result_beat_t      expected_results[$];
    int                errors = 0;

    bit byte_seen = 1'b0;
    bit res_seen  = 1'b0;
    bit cfg_seen  = 1'b0;

    parse_phase_t      phase_q;
    logic [BYTE_W-1:0] status_q;
    logic [BYTE_W-1:0] ctrl_q;
    logic [BYTE_W-1:0] sustain_q;
    logic [BYTE_W-1:0] portamento_q;

    logic [BYTE_W-1:0] gen_status = '0;

    task automatic report_error(input string msg);
        $display("%t ERROR %s", $realtime, msg);
        errors++;
    endtask

    function automatic result_beat_t track_pedals(input logic [BYTE_W-1:0] b);
        result_beat_t r;
        logic         one_data;
        r = '0;
        one_data = (status_q >= ONE_DATA_LOW) && (status_q <= ONE_DATA_HIGH);
        case (phase_q)
            PH_TAG:
            begin
                if (b == TAG_OVERFLOW)
                    r.frame_done = 1'b1;
                else
                    phase_q = PH_STATUS;
            end
            PH_STATUS:
            begin
                if (b[7])
                begin
                    status_q = b;
                    if (b >= MARK_LOW)
                    begin
                        r.frame_done = 1'b1;
                        phase_q = PH_TAG;
                    end
                    else
                        phase_q = PH_FIRST;
                end
                else if (one_data)
                begin
                    r.frame_done = 1'b1;
                    phase_q = PH_TAG;
                end
                else
                begin
                    ctrl_q = b;
                    phase_q = PH_SECOND;
                end
            end
            PH_FIRST:
            begin
                if (one_data)
                begin
                    r.frame_done = 1'b1;
                    phase_q = PH_TAG;
                end
                else
                begin
                    ctrl_q = b;
                    phase_q = PH_SECOND;
                end
            end
            default:
            begin
                if (status_q[7:4] == CONTROL_KIND)
                begin
                    if (ctrl_q == CTRL_SUSTAIN)
                    begin
                        sustain_q = b;
                        r.sustain_changed = 1'b1;
                    end
                    else if (ctrl_q == CTRL_PORTAMENTO)
                    begin
                        portamento_q = b;
                        r.portamento_changed = 1'b1;
                    end
                end
                r.frame_done = 1'b1;
                phase_q = PH_TAG;
            end
        endcase
        r.sustain_value    = sustain_q;
        r.portamento_value = portamento_q;
        return r;
    endfunction

    // monitor: sample all handshakes, predict on byte beats, check result beats
    always @(posedge clk)
    begin
        result_beat_t want;
        result_beat_t got;
        byte_seen = byte_ch.valid && byte_ch.ready;
        res_seen  = result_ch.valid && result_ch.ready;
        cfg_seen  = cfg_ch.valid && cfg_ch.ready;
        if (!rst_n)
        begin
            phase_q      = PH_TAG;
            status_q     = '0;
            ctrl_q       = '0;
            sustain_q    = PEDAL_REST_RESET;
            portamento_q = PEDAL_REST_RESET;
        end
        else
        begin
            if (cfg_seen)
            begin
                sustain_q    = cfg_ch.payload.pedal_rest_value;
                portamento_q = cfg_ch.payload.pedal_rest_value;
            end
            if (res_seen)
            begin
                got = result_ch.payload;
                if (expected_results.size() == 0)
                    report_error("result beat with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (got.sustain_value !== want.sustain_value)
                        report_error($sformatf("sustain_value got %02h expected %02h",
                            got.sustain_value, want.sustain_value));
                    if (got.portamento_value !== want.portamento_value)
                        report_error($sformatf("portamento_value got %02h expected %02h",
                            got.portamento_value, want.portamento_value));
                    if (got.sustain_changed !== want.sustain_changed)
                        report_error($sformatf("sustain_changed got %b expected %b",
                            got.sustain_changed, want.sustain_changed));
                    if (got.portamento_changed !== want.portamento_changed)
                        report_error($sformatf("portamento_changed got %b expected %b",
                            got.portamento_changed, want.portamento_changed));
                    if (got.frame_done !== want.frame_done)
                        report_error($sformatf("frame_done got %b expected %b",
                            got.frame_done, want.frame_done));
                end
            end
            if (byte_seen)
                expected_results.push_back(track_pedals(byte_ch.payload.stream_byte));
        end
    end

    int byte_gap  = 0;
    bit byte_calm = 1'b0;

    // driver: hold until taken, wait the drawn gap, then send the next beat
    always @(negedge clk)
    begin
        if (!rst_n)
            byte_valid_d <= 1'b0;
        else if (byte_valid_d && !byte_seen)
            ;
        else if (byte_gap > 0)
        begin
            byte_valid_d <= 1'b0;
            byte_gap--;
        end
        else if (pending_bytes.size() != 0)
        begin
            byte_data_d  <= pending_bytes.pop_front();
            byte_valid_d <= 1'b1;
            if ($urandom_range(0, 39) == 0)
                byte_calm = !byte_calm;
            byte_gap = byte_calm ? 0 : $urandom_range(0, 19);
        end
        else
            byte_valid_d <= 1'b0;
    end

    int res_stall = 0;
    bit res_calm  = 1'b0;

    always @(negedge clk)
    begin
        if (!rst_n)
            res_ready_d <= 1'b0;
        else
        begin
            if (res_seen)
            begin
                if ($urandom_range(0, 39) == 0)
                    res_calm = !res_calm;
                res_stall = res_calm ? 0 : $urandom_range(0, 19);
            end
            if (res_stall > 0)
            begin
                res_ready_d <= 1'b0;
                res_stall--;
            end
            else
                res_ready_d <= 1'b1;
        end
    end

    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        pending_bytes.push_back(b);
    endtask

    function automatic logic [BYTE_W-1:0] data_byte();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(0, 127));
    endfunction

    task automatic queue_frame(output int count);
        logic [BYTE_W-1:0] tag;
        logic [BYTE_W-1:0] st;
        int                pick;
        int                n;
        bit                one;
        count = 0;
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                queue_byte(8'($urandom_range(0, 255)));
                count++;
            end
            return;
        end
        if (pick < 16)
        begin
            queue_byte(TAG_OVERFLOW);
            count = 1;
            return;
        end
        tag = 8'($urandom_range(0, 255));
        if (tag == TAG_OVERFLOW)
            tag = tag ^ 8'h01;
        queue_byte(tag);
        count++;
        pick = $urandom_range(0, 19);
        if (pick < 4)
            st = '0;
        else if (pick < 12)
            st = {CONTROL_KIND, 4'($urandom_range(0, 15))};
        else if (pick < 15)
            st = 8'($urandom_range(ONE_DATA_LOW, ONE_DATA_HIGH));
        else if (pick < 17)
            st = 8'($urandom_range(8'h80, 8'hAF));
        else if (pick < 18)
            st = 8'($urandom_range(8'hE0, 8'hEF));
        else
            st = 8'($urandom_range(MARK_LOW, 8'hFF));
        if (st != '0)
        begin
            queue_byte(st);
            count++;
            gen_status = st;
            if (st >= MARK_LOW)
                return;
        end
        one = (gen_status >= ONE_DATA_LOW) && (gen_status <= ONE_DATA_HIGH);
        if ($urandom_range(0, 19) == 0)
            return;
        if (one)
        begin
            queue_byte(data_byte());
            count++;
            return;
        end
        pick = $urandom_range(0, 9);
        if (pick < 4)
            queue_byte(CTRL_SUSTAIN);
        else if (pick < 7)
            queue_byte(CTRL_PORTAMENTO);
        else
            queue_byte(data_byte());
        count++;
        if ($urandom_range(0, 19) == 0)
            return;
        queue_byte(data_byte());
        count++;
    endtask

    task automatic queue_random(input int target);
        int total;
        int n;
        total = 0;
        while (total < target)
        begin
            queue_frame(n);
            total += n;
        end
    endtask

    // settle past the driver's updates before checking for an idle pipeline
    task automatic wait_drained();
        do
        begin
            @(negedge clk);
            #1;
        end
        while (pending_bytes.size() != 0 || expected_results.size() != 0 || byte_valid_d);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_rest(input logic [BYTE_W-1:0] v);
        @(negedge clk);
        cfg_data_d  <= v;
        cfg_valid_d <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_seen);
        cfg_valid_d <= 1'b0;
    endtask

    logic [BYTE_W-1:0] directed_bytes[] = '{
        8'h00, 8'h10, 8'h20,
        8'hF8,
        8'h05, 8'hB3, 8'h40, 8'h7F,
        8'hFF, 8'h41, 8'h00,
        8'h01, 8'hB0, 8'h40, 8'h7F,
        8'h02, 8'hC5, 8'h12,
        8'h03, 8'h33,
        8'h04, 8'hF0,
        8'h06, 8'h90, 8'hFF, 8'h80
    };

    initial
    begin
        logic [BYTE_W-1:0] rest_values[4];
        rest_values[0] = 8'hFF;
        rest_values[1] = 8'h00;
        rest_values[2] = 8'($urandom_range(0, 255));
        rest_values[3] = 8'($urandom_range(0, 255));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_bytes[i])
            queue_byte(directed_bytes[i]);
        queue_random(300);
        wait_drained();
        foreach (rest_values[p])
        begin
            write_rest(rest_values[p]);
            @(posedge clk);
            queue_random(300);
            wait_drained();
        end
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d result beats never arrived", expected_results.size()));
        if (errors == 0)
            $display("tb_midi_pedal_controller_tracker: PASS");
        else
            $display("tb_midi_pedal_controller_tracker: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_midi_pedal_controller_tracker: FAIL");
        $finish;
    end

endmodule
